// File: hdl/ost_pkg.sv
// package: types, constants and corner tables for the octahedron tessellator
`timescale 1ns / 1ps
`default_nettype none
package ost_pkg;
  localparam int UnitW = 16;
  localparam int PosW = 17;
  localparam int LevelW = 2;
  localparam int RadiusW = 16;
  localparam int CfgW = 16;
  localparam int MaxLevelDef = 2;
  localparam logic signed [UnitW-1:0] UnitOne = 16'sd16384;

  localparam logic [0:0] CfgLevel = 1'b0;
  localparam logic [0:0] CfgRadius = 1'b1;

  typedef logic signed [UnitW-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;
  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t c;
  } tri_t;

  // datapath commands
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MIDS,
    OP_CHILD,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e       op;
    logic [1:0] depth;
    logic [1:0] child;
    logic [1:0] vsel;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_full;
  } sts_t;

  function automatic vec_t corner(input logic [2:0] k);
    vec_t v;
    v = '0;
    case (k)
      3'd0: v.z = UnitOne;
      3'd1: v.x = UnitOne;
      3'd2: v.y = UnitOne;
      3'd3: v.x = -UnitOne;
      3'd4: v.y = -UnitOne;
      3'd5: v.z = -UnitOne;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic tri_t face_tri(input logic [2:0] f);
    tri_t t;
    case (f)
      3'd0: t = '{corner(3'd0), corner(3'd1), corner(3'd2)};
      3'd1: t = '{corner(3'd0), corner(3'd2), corner(3'd3)};
      3'd2: t = '{corner(3'd0), corner(3'd3), corner(3'd4)};
      3'd3: t = '{corner(3'd0), corner(3'd4), corner(3'd1)};
      3'd4: t = '{corner(3'd5), corner(3'd2), corner(3'd1)};
      3'd5: t = '{corner(3'd5), corner(3'd3), corner(3'd2)};
      3'd6: t = '{corner(3'd5), corner(3'd4), corner(3'd3)};
      default: t = '{corner(3'd5), corner(3'd1), corner(3'd4)};
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

// File: hdl/ost_if.sv
// valid/ready channel interfaces for face and vertex transactions
`timescale 1ns / 1ps
`default_nettype none
interface ost_face_if;
  logic       valid;
  logic       ready;
  logic [2:0] face;
  modport source(output valid, output face, input ready);
  modport sink(input valid, input face, output ready);
endinterface

interface ost_vert_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [16:0] pos_z;
  logic               last;
  modport source(output valid, output pos_x, output pos_y, output pos_z, output last,
                 input ready);
  modport sink(input valid, input pos_x, input pos_y, input pos_z, input last,
               output ready);
endinterface
`default_nettype wire

// File: hdl/ost_datapath.sv
// datapath: triangle stack, midpoint normalizer, radius scaling, output register
`timescale 1ns / 1ps
`default_nettype none
module ost_datapath
  import ost_pkg::*;
#(
  parameter int MaxLevel = MaxLevelDef
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire cmd_t          cmd_i,
  input  wire [2:0]          face_i,
  input  wire [RadiusW-1:0]  radius_i,
  output sts_t               sts_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [PosW-1:0] pos_x_o,
  output logic signed [PosW-1:0] pos_y_o,
  output logic signed [PosW-1:0] pos_z_o,
  output logic               out_last_o
);
  localparam int Depth = MaxLevel + 1;
  localparam int DW = (Depth > 1) ? $clog2(Depth) : 1;

  tri_t stack_q [Depth];
  vec_t mid_q [3];
  vec_t sum_q;
  logic [1:0] midx_q;

  // unit state
  typedef enum logic [2:0] {
    U_IDLE, U_SQ, U_SQRT, U_DIV, U_STORE, U_SCALE, U_SCALE2
  } ustate_e;
  ustate_e u_q;

  logic [34:0] acc_q;       // sum of squares (max 3*2^30)
  logic [34:0] rem_q;
  logic [35:0] root_q;      // partial root runs as wide as the trial bit
  logic [35:0] bit_q;
  logic [1:0]  comp_q;
  logic [5:0]  cnt_q;
  logic [31:0] dnum_q;      // 2*|s|*2^14 + L numerator
  logic [31:0] drem_q;
  logic [16:0] quo_q;
  logic        neg_q;
  coord_t      res_q [3];
  vec_t        ev_q;
  logic signed [33:0] prod_q;
  logic        last_q;

  logic [DW-1:0] dep;
  assign dep = cmd_i.depth[DW-1:0];

  function automatic coord_t comp_of(input vec_t v, input logic [1:0] k);
    case (k)
      2'd0: return v.x;
      2'd1: return v.y;
      default: return v.z;
    endcase
  endfunction

  tri_t cur;
  assign cur = stack_q[dep];

  vec_t sum_a, sum_b;
  always_comb begin
    case (midx_q)
      2'd0: begin sum_a = cur.a; sum_b = cur.b; end
      2'd1: begin sum_a = cur.a; sum_b = cur.c; end
      default: begin sum_a = cur.c; sum_b = cur.b; end
    endcase
  end

  logic signed [16:0] s_comp;
  assign s_comp = 17'(comp_of(sum_q, comp_q));   // sums fit 16 bits signed
  logic [16:0] s_mag;
  assign s_mag = s_comp[16] ? 17'(-s_comp) : s_comp;
  logic [33:0] s_sq;
  assign s_sq = s_mag * s_mag;

  logic [35:0] trial;
  assign trial = {1'b0, rem_q} - (root_q + bit_q);

  logic [32:0] dtrial;
  logic [31:0] dsh;
  assign dsh = {drem_q[30:0], dnum_q[31]};
  assign dtrial = {1'b0, dsh} - {14'd0, root_q[17:0], 1'b0};

  logic signed [16:0] ev_comp;
  assign ev_comp = 17'(comp_of(ev_q, comp_q));

  logic [33:0] pmag;
  assign pmag = prod_q[33] ? 34'(-prod_q) : 34'(prod_q);
  logic [33:0] prnd;
  assign prnd = (pmag + 34'd8192) >> 14;

  assign sts_o.busy = (u_q != U_IDLE);
  assign sts_o.out_full = out_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q <= U_IDLE;
      out_valid_o <= 1'b0;
      midx_q <= '0;
      comp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      unique case (u_q)
        U_IDLE: begin
          unique case (cmd_i.op)
            OP_LOAD: stack_q[0] <= face_tri(face_i);
            OP_MIDS: begin midx_q <= 2'd0; u_q <= U_SQ; end
            OP_CHILD: begin
              unique case (cmd_i.child)
                2'd0: stack_q[dep+DW'(1)] <= '{cur.a, mid_q[0], mid_q[1]};
                2'd1: stack_q[dep+DW'(1)] <= '{cur.c, mid_q[1], mid_q[2]};
                2'd2: stack_q[dep+DW'(1)] <= '{cur.b, mid_q[2], mid_q[0]};
                default: stack_q[dep+DW'(1)] <= '{mid_q[2], mid_q[1], mid_q[0]};
              endcase
            end
            OP_EMIT: begin
              case (cmd_i.vsel)
                2'd0: ev_q <= cur.b;
                2'd1: ev_q <= cur.a;
                default: ev_q <= cur.c;
              endcase
              last_q <= cmd_i.last;
              comp_q <= 2'd0;
              u_q <= U_SCALE;
            end
            default: ;
          endcase
        end
        U_SQ: begin
          // form the sum, then accumulate squares one component a cycle
          if (cnt_q == 6'd0) begin
            sum_q.x <= sum_a.x + sum_b.x;
            sum_q.y <= sum_a.y + sum_b.y;
            sum_q.z <= sum_a.z + sum_b.z;
            acc_q <= '0;
            comp_q <= 2'd0;
            cnt_q <= 6'd1;
          end else begin
            acc_q <= acc_q + 35'(s_sq);
            if (comp_q == 2'd2) begin
              cnt_q <= '0;
              rem_q <= acc_q + 35'(s_sq);
              root_q <= '0;
              bit_q <= 36'd1 << 34;
              u_q <= U_SQRT;
            end else comp_q <= comp_q + 2'd1;
          end
        end
        U_SQRT: begin
          if (!trial[35]) begin
            rem_q <= trial[34:0];
            root_q <= (root_q >> 1) + bit_q;
          end else root_q <= root_q >> 1;
          bit_q <= bit_q >> 2;
          if (bit_q == 36'd1) begin
            comp_q <= 2'd0;
            cnt_q <= 6'd0;
            u_q <= U_DIV;
          end
        end
        U_DIV: begin
          // q = (2|s|*2^14 + L) / (2L), restoring, 32 bits
          if (cnt_q == 6'd0) begin
            dnum_q <= {s_mag[16:0], 15'd0} + {14'd0, root_q[17:0]};
            drem_q <= '0;
            neg_q <= s_comp[16];
            quo_q <= '0;
            cnt_q <= 6'd1;
          end else begin
            dnum_q <= dnum_q << 1;
            if (!dtrial[32]) begin
              drem_q <= dtrial[31:0];
              quo_q <= {quo_q[15:0], 1'b1};
            end else begin
              drem_q <= dsh;
              quo_q <= {quo_q[15:0], 1'b0};
            end
            if (cnt_q == 6'd32) begin
              cnt_q <= '0;
              u_q <= U_STORE;
            end else cnt_q <= cnt_q + 6'd1;
          end
        end
        U_STORE: begin
          if (root_q == '0) res_q[comp_q] <= '0;
          else if (quo_q > 17'd16384) res_q[comp_q] <= neg_q ? -UnitOne : UnitOne;
          else res_q[comp_q] <= neg_q ? -coord_t'(quo_q[15:0]) : coord_t'(quo_q[15:0]);
          if (comp_q == 2'd2) begin
            mid_q[midx_q] <= '{res_q[0], res_q[1],
                (root_q == '0) ? coord_t'(0) :
                (quo_q > 17'd16384) ? (neg_q ? -UnitOne : UnitOne) :
                (neg_q ? -coord_t'(quo_q[15:0]) : coord_t'(quo_q[15:0]))};
            if (midx_q == 2'd2) u_q <= U_IDLE;
            else begin midx_q <= midx_q + 2'd1; u_q <= U_SQ; end
          end else begin
            comp_q <= comp_q + 2'd1;
            u_q <= U_DIV;
          end
        end
        U_SCALE: begin
          prod_q <= ev_comp * $signed({1'b0, radius_i});
          u_q <= U_SCALE2;
        end
        U_SCALE2: begin
          res_q[comp_q] <= coord_t'(0);
          case (comp_q)
            2'd0: pos_x_o <= prod_q[33] ? -PosW'(prnd) : PosW'(prnd);
            2'd1: pos_y_o <= prod_q[33] ? -PosW'(prnd) : PosW'(prnd);
            default: pos_z_o <= prod_q[33] ? -PosW'(prnd) : PosW'(prnd);
          endcase
          if (comp_q == 2'd2) begin
            out_valid_o <= 1'b1;
            out_last_o <= last_q;
            u_q <= U_IDLE;
          end else begin
            comp_q <= comp_q + 2'd1;
            u_q <= U_SCALE;
          end
        end
        default: u_q <= U_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/ost_ctrl.sv
// controller: depth-first traversal sequencer issuing datapath commands
`timescale 1ns / 1ps
`default_nettype none
module ost_ctrl
  import ost_pkg::*;
#(
  parameter int MaxLevel = MaxLevelDef
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire [LevelW-1:0]  level_i,
  input  wire sts_t         sts_i,
  output cmd_t              cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_DESCEND, S_WAIT, S_CHILD, S_EMIT, S_EWAIT, S_ASCEND
  } state_e;
  state_e state_q;
  logic [1:0] depth_q, lvl_q, vsel_q;
  logic [1:0] pos_q [3];

  logic all_max;
  always_comb begin
    all_max = 1'b1;
    for (int i = 0; i < 3; i++)
      if (2'(i) < lvl_q && pos_q[i] != 2'd3) all_max = 1'b0;
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= '0;
      lvl_q <= '0;
      vsel_q <= '0;
      cmd_o <= '{OP_NONE, 2'd0, 2'd0, 2'd0, 1'b0};
      for (int i = 0; i < 3; i++) pos_q[i] <= '0;
    end else begin
      cmd_o.op <= OP_NONE;
      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          cmd_o.op <= OP_LOAD;
          lvl_q <= (level_i > 2'(MaxLevel)) ? 2'(MaxLevel) : level_i;
          depth_q <= '0;
          for (int i = 0; i < 3; i++) pos_q[i] <= '0;
          state_q <= S_DESCEND;
        end
        S_DESCEND: begin
          cmd_o.depth <= depth_q;
          if (depth_q < lvl_q) begin
            cmd_o.op <= OP_MIDS;
            state_q <= S_WAIT;
          end else begin
            vsel_q <= 2'd0;
            state_q <= S_EMIT;
          end
        end
        S_WAIT: if (cmd_o.op == OP_NONE && !sts_i.busy) state_q <= S_CHILD;
        S_CHILD: begin
          cmd_o.op <= OP_CHILD;
          cmd_o.child <= pos_q[depth_q];
          depth_q <= depth_q + 2'd1;
          state_q <= S_DESCEND;
        end
        S_EMIT: if (!sts_i.out_full && !sts_i.busy) begin
          cmd_o.op <= OP_EMIT;
          cmd_o.vsel <= vsel_q;
          cmd_o.depth <= depth_q;
          cmd_o.last <= (vsel_q == 2'd2) && all_max;
          state_q <= S_EWAIT;
        end
        S_EWAIT: if (cmd_o.op == OP_NONE && !sts_i.busy) begin
          if (vsel_q == 2'd2) state_q <= S_ASCEND;
          else begin vsel_q <= vsel_q + 2'd1; state_q <= S_EMIT; end
        end
        S_ASCEND: begin
          if (depth_q == 2'd0) state_q <= S_IDLE;
          else begin
            depth_q <= depth_q - 2'd1;
            if (pos_q[depth_q - 2'd1] < 2'd3) begin
              pos_q[depth_q - 2'd1] <= pos_q[depth_q - 2'd1] + 2'd1;
              pos_q[depth_q] <= '0;
              state_q <= S_DESCEND;
            end else pos_q[depth_q - 2'd1] <= '0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/octahedron_sphere_tessellator.sv
// top level: octahedron face to sphere mesh vertex generator
//
// usage: one transaction on face_in names an octahedron face; the block
// subdivides it level times (capped at MaxLevel) and emits 3*4^level
// vertex transactions on vert_out, last set on the final one of the face.
// config writes (index 0 level, index 1 radius in Q8.8) are for the user to
// make only while idle; the block itself does not enforce it.
// a face is accepted only when the previous face has finished.
// each midpoint squares the summed components, takes the square root and
// runs the rounded divisions (one restoring divider shared by all
// components); three midpoints per subdivision step. each vertex then
// goes through the scaling multiplier.
// a vertex sits in the output register until taken; the sequencer waits
// while it is full. reset clears level to 0 and radius to 1.0, no sweep.
`timescale 1ns / 1ps
`default_nettype none
module octahedron_sphere_tessellator
  import ost_pkg::*;
#(
  parameter int MaxLevel = MaxLevelDef
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire [0:0]        cfg_idx_i,
  input  wire [CfgW-1:0]   cfg_data_i,
  ost_face_if.sink         face_in,
  ost_vert_if.source       vert_out
);
  logic [LevelW-1:0]  level_q;
  logic [RadiusW-1:0] radius_q;
  logic [2:0]         face_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      radius_q <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLevel: level_q <= cfg_data_i[LevelW-1:0];
        CfgRadius: radius_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // face is captured with the transaction, the load follows in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_q <= '0;
    end else if (face_in.valid && face_in.ready) begin
      face_q <= face_in.face;
    end
  end

  ost_ctrl #(.MaxLevel(MaxLevel)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(face_in.valid), .in_ready_o(face_in.ready),
    .level_i(level_q), .sts_i(sts), .cmd_o(cmd)
  );

  ost_datapath #(.MaxLevel(MaxLevel)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .face_i(face_q), .radius_i(radius_q),
    .sts_o(sts), .out_valid_o(vert_out.valid), .out_ready_i(vert_out.ready),
    .pos_x_o(vert_out.pos_x), .pos_y_o(vert_out.pos_y), .pos_z_o(vert_out.pos_z),
    .out_last_o(vert_out.last)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    face_in.ready |-> !sts.busy) else $error("face accepted while datapath busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vert_out.valid && !vert_out.ready |=> vert_out.valid && $stable(vert_out.pos_x))
    else $error("vertex changed while stalled");
endmodule
`default_nettype wire

// File: test/octahedron_sphere_tessellator_chk.sv
// checker: predicts vertex transactions from accepted faces and compares them
`timescale 1ns / 1ps
`default_nettype none
module octahedron_sphere_tessellator_chk
  import ost_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            cfg_we_i,
  input  wire [0:0]      cfg_idx_i,
  input  wire [CfgW-1:0] cfg_data_i,
  input  wire            face_valid_i,
  input  wire            face_ready_i,
  input  wire [2:0]      face_i,
  input  wire            vert_valid_i,
  input  wire            vert_ready_i,
  input  wire [16:0]     pos_x_i,
  input  wire [16:0]     pos_y_i,
  input  wire [16:0]     pos_z_i,
  input  wire            last_i,
  output int             errors_o,
  output int             pending_o
);
  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic [16:0] z;
    logic        last;
  } vert_t;

  typedef longint unsigned u64_t;

  vert_t       vert_q[$];
  logic [1:0]  level_q;
  logic [15:0] radius_q;

  function automatic u64_t int_sqrt(input u64_t x);
    u64_t res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // rounded division, half away from zero
  function automatic longint round_div(input longint n, input longint d);
    longint mag, q;
    mag = n < 0 ? -n : n;
    q = (2 * mag + d) / (2 * d);
    return n < 0 ? -q : q;
  endfunction

  function automatic vec_t unit_mid(input vec_t p, input vec_t q);
    longint s[3], v;
    u64_t sq, len;
    vec_t r;
    s[0] = longint'(p.x) + longint'(q.x);
    s[1] = longint'(p.y) + longint'(q.y);
    s[2] = longint'(p.z) + longint'(q.z);
    sq = 0;
    for (int i = 0; i < 3; i++) sq += u64_t'(s[i] * s[i]);
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      v = (len == 0) ? 0 : round_div(s[i] * 16384, longint'(len));
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      s[i] = v;
    end
    r.x = coord_t'(s[0]);
    r.y = coord_t'(s[1]);
    r.z = coord_t'(s[2]);
    return r;
  endfunction

  function automatic logic [16:0] scale(input coord_t u);
    longint p;
    p = round_div(longint'(u) * longint'({1'b0, radius_q}), 16384);
    return p[16:0];
  endfunction

  task automatic push_vert(input vec_t v);
    vert_t e;
    e.x = scale(v.x);
    e.y = scale(v.y);
    e.z = scale(v.z);
    e.last = 1'b0;
    vert_q = {vert_q, e};
  endtask

  task automatic subdivide(input vec_t a, input vec_t b, input vec_t c, input int depth);
    vec_t m1, m2, m3;
    if (depth == 0) begin
      push_vert(b);
      push_vert(a);
      push_vert(c);
    end else begin
      m1 = unit_mid(a, b);
      m2 = unit_mid(a, c);
      m3 = unit_mid(c, b);
      subdivide(a, m1, m2, depth - 1);
      subdivide(c, m2, m3, depth - 1);
      subdivide(b, m3, m1, depth - 1);
      subdivide(m3, m2, m1, depth - 1);
    end
  endtask

  function automatic vec_t corner_of(input int k);
    vec_t v;
    v = '0;
    case (k)
      0: v.z = UnitOne;
      1: v.x = UnitOne;
      2: v.y = UnitOne;
      3: v.x = -UnitOne;
      4: v.y = -UnitOne;
      default: v.z = -UnitOne;
    endcase
    return v;
  endfunction

  task automatic predict_face(input logic [2:0] f);
    int ca[8] = '{0, 0, 0, 0, 5, 5, 5, 5};
    int cb[8] = '{1, 2, 3, 4, 2, 3, 4, 1};
    int cc[8] = '{2, 3, 4, 1, 1, 2, 3, 4};
    int lvl;
    lvl = (level_q > 2) ? 2 : level_q;
    subdivide(corner_of(ca[f]), corner_of(cb[f]), corner_of(cc[f]), lvl);
    vert_q[$].last = 1'b1;
  endtask

  vert_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q = 2'd0;
      radius_q = 16'd256;
      errors_o = 0;
      vert_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgLevel) level_q = cfg_data_i[1:0];
        else radius_q = cfg_data_i[15:0];
      end
      if (vert_valid_i && vert_ready_i) begin
        got = '{pos_x_i, pos_y_i, pos_z_i, last_i};
        if (vert_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected vertex %p", got);
        end else begin
          want = vert_q.pop_front();
          if (got !== want) begin
            errors_o++;
            if (errors_o <= 10) $display("vertex mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (face_valid_i && face_ready_i) predict_face(face_i);
    end
    pending_o = vert_q.size();
  end
endmodule
`default_nettype wire

// File: test/octahedron_sphere_tessellator_tb.sv
// testbench top: face stimulus, config phases, receiver stalls and verdict
`timescale 1ns / 1ps
`default_nettype none
module octahedron_sphere_tessellator_tb;
  import ost_pkg::*;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [0:0]      cfg_idx_i = CfgLevel;
  logic [CfgW-1:0] cfg_data_i = '0;
  int              errors, pending;
  bit              calm = 1'b0;
  bit              hold_rx = 1'b0;

  ost_face_if face_in();
  ost_vert_if vert_out();

  octahedron_sphere_tessellator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .face_in(face_in.sink), .vert_out(vert_out.source)
  );

  octahedron_sphere_tessellator_chk chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .face_valid_i(face_in.valid), .face_ready_i(face_in.ready), .face_i(face_in.face),
    .vert_valid_i(vert_out.valid), .vert_ready_i(vert_out.ready),
    .pos_x_i(vert_out.pos_x), .pos_y_i(vert_out.pos_y), .pos_z_i(vert_out.pos_z),
    .last_i(vert_out.last), .errors_o(errors), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    face_in.valid = 1'b0;
    face_in.face = '0;
    vert_out.ready = 1'b0;
  end

  // receiver: random stall bursts, or a long hold-off when asked
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        vert_out.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        vert_out.ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end else begin
        vert_out.ready <= 1'b1;
      end
    end
  end

  task automatic send_face(input logic [2:0] f);
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 16)) @(negedge clk_i);
    else @(negedge clk_i);
    face_in.valid <= 1'b1;
    face_in.face <= f;
    @(posedge clk_i);
    while (!face_in.ready) @(posedge clk_i);
    @(negedge clk_i);
    face_in.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int lvl;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    // reset defaults, every face
    for (int f = 0; f < 8; f++) send_face(f[2:0]);
    drain();
    // extremes: level 3 saturates, max radius, zero radius, min radius
    write_cfg(CfgLevel, 16'd3);
    write_cfg(CfgRadius, 16'hFFFF);
    send_face(3'd0);
    send_face(3'd7);
    drain();
    write_cfg(CfgLevel, 16'hFFFE);
    write_cfg(CfgRadius, 16'd0);
    send_face(3'd5);
    drain();
    write_cfg(CfgRadius, 16'd1);
    write_cfg(CfgLevel, 16'd1);
    for (int f = 0; f < 8; f++) send_face(f[2:0]);
    drain();
    // long receiver hold-off while faces keep coming
    hold_rx = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_rx = 1'b0;
      end
      repeat (4) send_face(3'($urandom_range(0, 7)));
    join
    drain();
    // random phases, level mostly small
    for (int ph = 0; ph < 10; ph++) begin
      lvl = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(0, 1);
      write_cfg(CfgLevel, 16'({$urandom} & 16'hFFFF & (lvl == 2 ? 16'h3 : 16'hFFF1 | lvl)));
      write_cfg(CfgRadius, 16'($urandom_range(0, 65535)));
      if (ph == 8) calm = 1'b1;
      repeat (lvl == 2 ? 3 : 12) send_face(3'($urandom_range(0, 7)));
      drain();
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
